// ===== rtl/core/sklist_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the sorted key list
package sklist_pkg;

    localparam int SKL_CAPACITY = 16;
    localparam int SKL_KEY_BITS = 32;
    localparam int SKL_TAG_BITS = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic clr;
    } cell_cmd_t;

endpackage

// ===== rtl/core/sklist_cell.sv =====
`timescale 1ns / 1ps
// one slot of the sorted chain: compares against the broadcast key and shifts
module sklist_cell #(
    parameter int KEY_BITS = sklist_pkg::SKL_KEY_BITS,
    parameter int TAG_BITS = sklist_pkg::SKL_TAG_BITS
) (
    input  logic                    clk,
    input  sklist_pkg::cell_cmd_t   cmd,
    input  logic                    valid,
    input  logic [KEY_BITS-1:0]     in_key,
    input  logic [TAG_BITS-1:0]     in_tag,
    input  logic                    left_lt,
    input  logic [KEY_BITS-1:0]     left_key,
    input  logic [TAG_BITS-1:0]     left_tag,
    input  logic [KEY_BITS-1:0]     right_key,
    input  logic [TAG_BITS-1:0]     right_tag,
    output logic                    lt,
    output logic                    hit,
    output logic [KEY_BITS-1:0]     key_out,
    output logic [TAG_BITS-1:0]     tag_out,
    output logic [KEY_BITS-1:0]     key_next,
    output logic [TAG_BITS-1:0]     tag_next
);
    import sklist_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [TAG_BITS-1:0] tag_reg;

    assign lt  = valid && ($signed(key_reg) < $signed(in_key));
    // first entry not below the key, and equal to it
    assign hit = valid && left_lt && (key_reg == in_key);

    assign key_out = key_reg;
    assign tag_out = tag_reg;

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (cmd.ins && !lt)
        begin
            if (left_lt)
            begin
                key_next = in_key;
                tag_next = in_tag;
            end
            else
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
        end
        else if (cmd.del && !lt)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

// ===== rtl/core/sorted_key_list_top.sv =====
`timescale 1ns / 1ps
// sorted key list: a row of compare-and-shift cells with a registered result
// the result is valid in the cycle after the transaction is accepted
// throughput: one operation per cycle while results are drained; every cell compares and shifts at once
// input is taken whenever the result register is empty or being drained
// reset clears the internal entry count and the result valid; slot contents stay as is
module sorted_key_list_top #(
    parameter int CAPACITY = sklist_pkg::SKL_CAPACITY,
    parameter int KEY_BITS = sklist_pkg::SKL_KEY_BITS,
    parameter int TAG_BITS = sklist_pkg::SKL_TAG_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      func,
    input  logic signed [KEY_BITS-1:0]      key,
    input  logic [TAG_BITS-1:0]             tag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
    output logic                            head_valid,
    output logic signed [KEY_BITS-1:0]      head_key,
    output logic [TAG_BITS-1:0]             head_tag
);
    import sklist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                   accept;
    logic                   full;
    logic                   found;
    cell_cmd_t              cmd;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [1:0]             status_next;

    logic                   out_valid_reg;
    logic [1:0]             status_reg;
    logic [CW-1:0]          entry_count_reg;
    logic                   head_valid_reg;
    logic [KEY_BITS-1:0]    head_key_reg;
    logic [TAG_BITS-1:0]    head_tag_reg;

    logic [CAPACITY-1:0]    cell_valid;
    logic [CAPACITY:0]      lt_chain;
    logic [CAPACITY-1:0]    hit_vec;
    logic [KEY_BITS-1:0]    cell_key [CAPACITY+1];
    logic [TAG_BITS-1:0]    cell_tag [CAPACITY+1];
    logic [KEY_BITS-1:0]    cell_key_next [CAPACITY];
    logic [TAG_BITS-1:0]    cell_tag_next [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign found    = |hit_vec;

    assign cmd.ins = accept && (func == OP_INSERT) && !full;
    assign cmd.del = accept && (func == OP_DELETE) && found;
    assign cmd.clr = accept && (func == OP_CLEAR);

    // the first cell sees an always-below left neighbor
    assign lt_chain[0] = 1'b1;
    assign cell_key[CAPACITY] = '0;
    assign cell_tag[CAPACITY] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [KEY_BITS-1:0] left_key;
            logic [TAG_BITS-1:0] left_tag;

            assign cell_valid[gi] = (count_reg > CW'(gi));

            if (gi == 0)
            begin : g_first
                assign left_key = '0;
                assign left_tag = '0;
            end
            else
            begin : g_rest
                assign left_key = cell_key[gi-1];
                assign left_tag = cell_tag[gi-1];
            end

            sklist_cell #(
                .KEY_BITS (KEY_BITS),
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .valid     (cell_valid[gi]),
                .in_key    (key),
                .in_tag    (tag),
                .left_lt   (lt_chain[gi]),
                .left_key  (left_key),
                .left_tag  (left_tag),
                .right_key (cell_key[gi+1]),
                .right_tag (cell_tag[gi+1]),
                .lt        (lt_chain[gi+1]),
                .hit       (hit_vec[gi]),
                .key_out   (cell_key[gi]),
                .tag_out   (cell_tag[gi]),
                .key_next  (cell_key_next[gi]),
                .tag_next  (cell_tag_next[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
            count_next = '0;
        else if (cmd.ins)
            count_next = count_reg + CW'(1);
        else if (cmd.del)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        unique case (func)
            OP_INSERT: status_next = full ? ST_FULL : ST_DONE;
            OP_DELETE: status_next = found ? ST_DONE : ST_NOT_FOUND;
            default:   status_next = ST_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            entry_count_reg <= count_next;
            head_valid_reg  <= (count_next != '0);
            head_key_reg    <= (count_next != '0) ? cell_key_next[0] : '0;
            head_tag_reg    <= (count_next != '0) ? cell_tag_next[0] : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign head_valid  = head_valid_reg;
    assign head_key    = head_key_reg;
    assign head_tag    = head_tag_reg;

endmodule

// ===== rtl/core/sorted_key_list_chk.sv =====
`timescale 1ns / 1ps
// port-level checks for the sorted key list, bound to the top level
module sorted_key_list_chk #(
    parameter int CAPACITY = sklist_pkg::SKL_CAPACITY,
    parameter int KEY_BITS = sklist_pkg::SKL_KEY_BITS,
    parameter int TAG_BITS = sklist_pkg::SKL_TAG_BITS
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [1:0]                       status,
    input logic [$clog2(CAPACITY+1)-1:0]    entry_count,
    input logic                             head_valid,
    input logic signed [KEY_BITS-1:0]       head_key,
    input logic [TAG_BITS-1:0]              head_tag
);
    import sklist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(entry_count) && $stable(head_key) && $stable(head_tag))
        else $error("result changed while stalled");

    // each accepted transaction yields a result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction produced no result");

    a_head_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (entry_count != '0))
            && (entry_count <= CW'(CAPACITY))
            && (head_valid || (head_key == '0 && head_tag == '0)))
        else $error("head fields disagree with entry count");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == CW'(CAPACITY))
        else $error("full status with room left");

endmodule

bind sorted_key_list_top sorted_key_list_chk #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
) u_sorted_key_list_chk (.*);
